>>> design/tcc_pkg.sv
// tcc_pkg: shared types and constants for the text console with cursor and scroll
// holds character codes, field widths, operation and sequencer state encodings
// no dependencies
package tcc_pkg;

  // field widths of the item channels
  localparam int CODE_W    = 8;
  localparam int RD_ROW_W  = 5;
  localparam int RD_COL_W  = 7;
  localparam int CELL_W    = 8;
  localparam int CUR_ROW_W = 5;
  localparam int CUR_COL_W = 7;

  // control characters
  localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CODE_W-1:0] CH_SPACE     = 8'd32;

  // decoded operation of one item
  typedef enum logic [2:0] {
    OP_READ,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_TAB,
    OP_CHAR
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_DONE
  } tcc_state_t;

endpackage

>>> design/tcc_in_if.sv
// tcc_in_if: input item channel (valid/ready plus payload)
// depends on tcc_pkg for field widths
interface tcc_in_if;
  import tcc_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [CODE_W-1:0]   char_code;
  logic [RD_ROW_W-1:0] read_row;
  logic [RD_COL_W-1:0] read_col;

  modport source (output valid, mode, char_code, read_row, read_col, input ready);
  modport sink   (input valid, mode, char_code, read_row, read_col, output ready);
endinterface

>>> design/tcc_out_if.sv
// tcc_out_if: result item channel (valid/ready plus payload)
// depends on tcc_pkg for field widths
interface tcc_out_if;
  import tcc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CELL_W-1:0]    cell_value;
  logic [CUR_ROW_W-1:0] cursor_row;
  logic [CUR_COL_W-1:0] cursor_col;
  logic                 scrolled;

  modport source (output valid, cell_value, cursor_row, cursor_col, scrolled, input ready);
  modport sink   (input valid, cell_value, cursor_row, cursor_col, scrolled, output ready);
endinterface

>>> design/tcc_ram.sv
// tcc_ram: generic single-write, single-read synchronous ram
// read data is registered and holds while rd_en is low; no dependencies
module tcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/tcc_ctrl.sv
// tcc_ctrl: cursor, scroll offset and put/read sequencer of the text console
// keeps rows in a ring (row base register) so a scroll only blanks one row
// depends on tcc_pkg, tcc_in_if, tcc_out_if
module tcc_ctrl #(
  parameter int ROWS      = 25,
  parameter int COLS      = 80,
  parameter int TAB_WIDTH = 4,
  parameter int RW        = $clog2(ROWS),
  parameter int CW        = $clog2(COLS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clearing,
  tcc_in_if.sink                      in_ch,
  tcc_out_if.source                   out_ch,
  output logic                        wr_en,
  output logic [RW+CW-1:0]            wr_addr,
  output logic [tcc_pkg::CELL_W-1:0]  wr_data,
  output logic                        rd_en,
  output logic [RW+CW-1:0]            rd_addr,
  input  logic [tcc_pkg::CELL_W-1:0]  rd_data
);
  import tcc_pkg::*;

  localparam int TW = $clog2(TAB_WIDTH + 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

  tcc_state_t state_r, state_nxt;
  op_t        op_r, op_nxt;

  logic [CODE_W-1:0]    code_r, code_nxt;
  logic [RD_ROW_W-1:0]  rr_r, rr_nxt;
  logic [RD_COL_W-1:0]  rc_r, rc_nxt;
  logic [RW-1:0]        cur_row_r, cur_row_nxt;
  logic [CW-1:0]        cur_col_r, cur_col_nxt;
  logic [RW-1:0]        base_r, base_nxt;
  logic [RW-1:0]        blank_row_r, blank_row_nxt;
  logic [CW-1:0]        sweep_r, sweep_nxt;
  logic [TW-1:0]        tab_left_r, tab_left_nxt;
  logic                 scrolled_r, scrolled_nxt;
  logic                 hit_r, hit_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]    out_cell_r, out_cell_nxt;
  logic [CUR_ROW_W-1:0] out_row_r, out_row_nxt;
  logic [CUR_COL_W-1:0] out_col_r, out_col_nxt;
  logic                 out_scr_r, out_scr_nxt;

  logic       slot_free;
  logic       take;
  logic       start_scroll;
  logic       rd_in_range;
  logic [RW-1:0] base_inc;
  op_t        op_dec;

  // logical row to physical row of the ring
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
                                             input logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, lr} + {1'b0, b};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  // handshake
  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !clearing &&
                        ((state_r == S_IDLE) || ((state_r == S_DONE) && slot_free));
  assign take         = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_value = out_cell_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.scrolled   = out_scr_r;

  // decode of the incoming item
  always_comb begin
    if (in_ch.mode) begin
      op_dec = OP_READ;
    end else begin
      case (in_ch.char_code)
        CH_NEWLINE:   op_dec = OP_NEWLINE;
        CH_BACKSPACE: op_dec = OP_BACKSPACE;
        CH_TAB:       op_dec = OP_TAB;
        default:      op_dec = OP_CHAR;
      endcase
    end
  end

  assign rd_in_range = (32'(rr_r) < ROWS) && (32'(rc_r) < COLS);
  assign base_inc    = (base_r == LAST_ROW) ? '0 : base_r + 1'b1;

  // sequencer: next state, cursor and memory accesses
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    code_nxt      = code_r;
    rr_nxt        = rr_r;
    rc_nxt        = rc_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    base_nxt      = base_r;
    blank_row_nxt = blank_row_r;
    sweep_nxt     = sweep_r;
    tab_left_nxt  = tab_left_r;
    scrolled_nxt  = scrolled_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cell_nxt  = out_cell_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_scr_nxt   = out_scr_r;
    start_scroll  = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = {phys_row(cur_row_r, base_r), cur_col_r};
    wr_data       = CH_SPACE;
    rd_en         = 1'b0;
    rd_addr       = {phys_row(RW'(rr_r), base_r), CW'(rc_r)};

    case (state_r)
      S_IDLE: begin
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_READ: begin
            rd_en   = rd_in_range;
            hit_nxt = rd_in_range;
          end
          OP_NEWLINE: begin
            cur_col_nxt = '0;
            if (cur_row_r == LAST_ROW) begin
              start_scroll = 1'b1;
            end else begin
              cur_row_nxt = cur_row_r + 1'b1;
            end
          end
          OP_BACKSPACE: begin
            if (cur_col_r != '0) begin
              cur_col_nxt = cur_col_r - 1'b1;
              wr_en       = 1'b1;
              wr_addr     = {phys_row(cur_row_r, base_r), cur_col_r - 1'b1};
            end else if (cur_row_r != '0) begin
              cur_row_nxt = cur_row_r - 1'b1;
              cur_col_nxt = LAST_COL;
              wr_en       = 1'b1;
              wr_addr     = {phys_row(cur_row_r - 1'b1, base_r), LAST_COL};
            end
          end
          default: begin
            // plain character or one space of a tab: store, advance, wrap
            wr_en   = 1'b1;
            wr_data = (op_r == OP_TAB) ? CH_SPACE : code_r;
            if (cur_col_r == LAST_COL) begin
              cur_col_nxt = '0;
              if (cur_row_r == LAST_ROW) begin
                start_scroll = 1'b1;
              end else begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
            end else begin
              cur_col_nxt = cur_col_r + 1'b1;
            end
            if (op_r == OP_TAB) begin
              tab_left_nxt = tab_left_r - 1'b1;
              if (tab_left_r != TW'(1)) begin
                state_nxt = S_EXEC;
              end
            end
          end
        endcase
      end

      S_SCROLL: begin
        // blank the row that came around to the bottom
        wr_en     = 1'b1;
        wr_addr   = {blank_row_r, sweep_r};
        wr_data   = CH_SPACE;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_COL) begin
          sweep_nxt = '0;
          state_nxt = ((op_r == OP_TAB) && (tab_left_r != '0)) ? S_EXEC : S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = ((op_r == OP_READ) && hit_r) ? rd_data : '0;
          out_row_nxt   = CUR_ROW_W'(cur_row_r);
          out_col_nxt   = CUR_COL_W'(cur_col_r);
          out_scr_nxt   = (op_r != OP_READ) && scrolled_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // scroll: rotate the ring and start blanking the old top row
    if (start_scroll) begin
      base_nxt      = base_inc;
      blank_row_nxt = base_r;
      sweep_nxt     = '0;
      scrolled_nxt  = 1'b1;
      state_nxt     = S_SCROLL;
    end

    // new item
    if (take) begin
      op_nxt       = op_dec;
      code_nxt     = in_ch.char_code;
      rr_nxt       = in_ch.read_row;
      rc_nxt       = in_ch.read_col;
      scrolled_nxt = 1'b0;
      hit_nxt      = 1'b0;
      tab_left_nxt = TW'(TAB_WIDTH);
      state_nxt    = S_EXEC;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      base_r      <= '0;
      sweep_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      base_r      <= base_nxt;
      sweep_r     <= sweep_nxt;
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    code_r      <= code_nxt;
    rr_r        <= rr_nxt;
    rc_r        <= rc_nxt;
    blank_row_r <= blank_row_nxt;
    tab_left_r  <= tab_left_nxt;
    scrolled_r  <= scrolled_nxt;
    hit_r       <= hit_nxt;
    out_cell_r  <= out_cell_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  // cursor and ring base stay inside the grid
  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cur_row_r) < ROWS) && (32'(cur_col_r) < COLS))
    else $error("cursor left the grid");

  a_base_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    32'(base_r) < ROWS)
    else $error("row base out of range");

  // a scroll only happens with the cursor on the bottom row
  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> (cur_row_r == LAST_ROW))
    else $error("scroll with cursor off the bottom row");

  // the blanked row is the one the cursor now sits on
  a_blank_is_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> (phys_row(cur_row_r, base_r) == blank_row_r))
    else $error("blanking a row other than the bottom row");

endmodule

>>> design/text_console_cursor_scroll.sv
// text_console_cursor_scroll: character-grid console with cursor, wrap and scroll
// a put, read, newline or backspace item runs execute, then the result register,
// held while the output stalls; the next item is taken in the cycle the result
// is loaded; a tab repeats execute TAB_WIDTH times, a scroll blanks COLS cells;
// the single-port-write screen ram bounds the rate: one cell write per cycle
// after reset a clearing pass zeroes ROWS*2^clog2(COLS) cells with the input
// not ready; reset is synchronous, active low
module text_console_cursor_scroll #(
  parameter int ROWS      = 25,
  parameter int COLS      = 80,
  parameter int TAB_WIDTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  tcc_in_if.sink    in_ch,
  tcc_out_if.source out_ch
);
  import tcc_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int DEPTH = ROWS << CW;
  localparam int AW    = $clog2(DEPTH);

  logic              clearing_r, clearing_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;

  logic              ctl_wr_en;
  logic [AW-1:0]     ctl_wr_addr;
  logic [CELL_W-1:0] ctl_wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [CELL_W-1:0] ram_wr_data;

  // clearing pass after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // ram write port: clearing pass or sequencer
  assign ram_wr_en   = clearing_r || ctl_wr_en;
  assign ram_wr_addr = clearing_r ? clr_addr_r : ctl_wr_addr;
  assign ram_wr_data = clearing_r ? '0 : ctl_wr_data;

  tcc_ctrl #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .TAB_WIDTH (TAB_WIDTH),
    .RW        (RW),
    .CW        (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing_r),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .wr_en    (ctl_wr_en),
    .wr_addr  (ctl_wr_addr),
    .wr_data  (ctl_wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // no item is taken and no sequencer access happens during the clearing pass
  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!in_ch.ready && !ctl_wr_en && !rd_en))
    else $error("access during clearing pass");

  // the clearing pass ends exactly after the last entry
  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> ($past(clr_addr_r) == AW'(DEPTH - 1)))
    else $error("clearing pass ended early");

endmodule
